/* sv/esc_pkg.sv */
// ============================================================================
// esc_pkg: shared types and constants for the epoch-to-calendar converter
// Transaction structs, sequencer states, divider request/response and
// cumulative month tables.
// ============================================================================
package esc_pkg;

    typedef struct packed {
        logic signed [31:0] epoch_seconds;
        logic               local_mode;
    } esc_in_t;

    typedef struct packed {
        logic       bad_time;
        logic [7:0] year_since_1900;
        logic [3:0] month_index;
        logic [4:0] day_of_month;
        logic [8:0] day_of_year;
        logic [2:0] weekday;
        logic [4:0] hour_of_day;
        logic [5:0] minute_of_hour;
        logic [5:0] second_of_minute;
    } esc_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DAYS,
        ST_WDAY,
        ST_YEAR,
        ST_HOUR,
        ST_MIN,
        ST_DONE
    } esc_state_t;

    typedef struct packed {
        logic        start;
        logic [31:0] dividend;
        logic [31:0] divisor;
        logic [4:0]  steps;
    } esc_div_req_t;

    typedef struct packed {
        logic        done;
        logic [15:0] quotient;
        logic [31:0] remainder;
    } esc_div_rsp_t;

    // Divisors aligned to the top quotient bit of each step count
    localparam logic [31:0] DAY_DIVISOR   = 32'd86400 << 15;
    localparam logic [4:0]  DAY_STEPS     = 5'd16;
    localparam logic [31:0] WEEK_DIVISOR  = 32'd7 << 12;
    localparam logic [4:0]  WEEK_STEPS    = 5'd13;
    localparam logic [31:0] QUAD_DIVISOR  = 32'd1461 << 5;
    localparam logic [4:0]  QUAD_STEPS    = 5'd6;
    localparam logic [31:0] HOUR_DIVISOR  = 32'd3600 << 4;
    localparam logic [4:0]  HOUR_STEPS    = 5'd5;
    localparam logic [31:0] MIN_DIVISOR   = 32'd60 << 5;
    localparam logic [4:0]  MIN_STEPS     = 5'd6;

    localparam logic signed [16:0] OFFSET_RESET  = 17'sd28800;
    localparam logic [32:0]        SEC_PER_DAY   = 33'd86400;
    localparam logic [2:0]         EPOCH_WEEKDAY = 3'd4;
    localparam logic [7:0]         BASE_YEAR     = 8'd70;

    localparam logic [7:0] PRE_EPOCH_YEAR  = 8'd69;
    localparam logic [3:0] PRE_EPOCH_MONTH = 4'd11;
    localparam logic [4:0] PRE_EPOCH_MDAY  = 5'd31;
    localparam logic [8:0] PRE_EPOCH_YDAY  = 9'd364;
    localparam logic [2:0] PRE_EPOCH_WDAY  = 3'd3;

    localparam logic [8:0] MONTH_START_COMMON [12] = '{
        9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
        9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334
    };
    localparam logic [8:0] MONTH_START_LEAP [12] = '{
        9'd0, 9'd31, 9'd60, 9'd91, 9'd121, 9'd152,
        9'd182, 9'd213, 9'd244, 9'd274, 9'd305, 9'd335
    };

endpackage

/* sv/esc_divider.sv */
// ============================================================================
// esc_divider: shared restoring divider
// One compare-subtract per cycle over a pre-aligned divisor; pulses done
// with quotient and remainder held until the next start.
// ============================================================================
module esc_divider (
    input  logic                  clk,
    input  logic                  rst_n,
    input  esc_pkg::esc_div_req_t req,
    output esc_pkg::esc_div_rsp_t rsp
);

    logic [31:0] rem_reg;
    logic [31:0] rem_next;
    logic [31:0] dsh_reg;
    logic [31:0] dsh_next;
    logic [15:0] quo_reg;
    logic [15:0] quo_next;
    logic [4:0]  cnt_reg;
    logic [4:0]  cnt_next;
    logic        busy_reg;
    logic        busy_next;
    logic        done_reg;
    logic        done_next;
    logic        ge;

    assign ge = (rem_reg >= dsh_reg);

    always_comb
    begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            rem_next  = req.dividend;
            dsh_next  = req.divisor;
            quo_next  = '0;
            cnt_next  = req.steps;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? (rem_reg - dsh_reg) : rem_reg;
            dsh_next = dsh_reg >> 1;
            quo_next = {quo_reg[14:0], ge};
            cnt_next = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        quo_reg <= quo_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

endmodule

/* sv/esc_date.sv */
// ============================================================================
// esc_date: four-year cycle to calendar date
// Splits the day within a four-year cycle into year, day of year, month
// and day of month.
// ============================================================================
module esc_date (
    input  logic [5:0]  cycle_count,
    input  logic [10:0] cycle_day,
    output logic [7:0]  year,
    output logic [3:0]  month,
    output logic [4:0]  mday,
    output logic [8:0]  yday
);

    logic [1:0]  year_off;
    logic        leap;
    logic [10:0] day_base;
    logic [8:0]  tab [12];

    always_comb
    begin
        if (cycle_day < 11'd365)
        begin
            year_off = 2'd0;
            leap     = 1'b0;
            day_base = 11'd0;
        end
        else if (cycle_day < 11'd730)
        begin
            year_off = 2'd1;
            leap     = 1'b0;
            day_base = 11'd365;
        end
        else if (cycle_day < 11'd1096)
        begin
            year_off = 2'd2;
            leap     = 1'b1;
            day_base = 11'd730;
        end
        else
        begin
            year_off = 2'd3;
            leap     = 1'b0;
            day_base = 11'd1096;
        end
    end

    assign yday = 9'(cycle_day - day_base);
    assign year = esc_pkg::BASE_YEAR + {cycle_count, 2'b00} + 8'(year_off);

    always_comb
    begin
        for (int k = 0; k < 12; k++)
        begin
            tab[k] = leap ? esc_pkg::MONTH_START_LEAP[k] : esc_pkg::MONTH_START_COMMON[k];
        end
    end

    always_comb
    begin
        month = 4'd0;
        for (int k = 1; k < 12; k++)
        begin
            if (tab[k] <= yday)
            begin
                month = 4'(k);
            end
        end
    end

    assign mday = 5'(yday - tab[month] + 9'd1);

endmodule

/* sv/epoch_seconds_to_calendar.sv */
// ============================================================================
// epoch_seconds_to_calendar: epoch seconds to broken-down calendar time
// Sequencer around one shared restoring divider.
// ============================================================================
// Usage:
//   src_valid/src_ready/src_data carry one timestamp per transaction;
//   res_valid/res_ready/res_data carry one calendar result per transaction.
//   cfg_we with cfg_data writes the signed zone offset used in local mode.
// Timing:
//   A normal timestamp runs five divisions (day, weekday, four-year cycle,
//   hour, minute) on the shared divider, one quotient bit per cycle.
//   A local time that falls before the epoch runs only the hour and minute
//   divisions; a negative input goes straight to the done state with no
//   division. src_ready is high only while the sequencer is idle, so a new
//   timestamp is taken only after the previous result has left the
//   sequencer for the output register.
// Reset:
//   Clears the sequencer and the output valid; offset returns to +28800.
// Stall:
//   The output register holds a result while res_ready is low; a new
//   timestamp is still taken and its result waits in the last step.
// ============================================================================
module epoch_seconds_to_calendar (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    src_valid,
    output logic                    src_ready,
    input  esc_pkg::esc_in_t        src_data,
    output logic                    res_valid,
    input  logic                    res_ready,
    output esc_pkg::esc_out_t       res_data,
    input  logic                    cfg_we,
    input  logic signed [16:0]      cfg_data
);

    esc_pkg::esc_state_t   state_reg;
    esc_pkg::esc_state_t   state_next;
    esc_pkg::esc_div_req_t div_req;
    esc_pkg::esc_div_rsp_t div_rsp;

    logic signed [16:0] offset_reg;
    logic [15:0]        days_reg;
    logic [16:0]        secs_reg;
    logic [2:0]         wday_reg;
    logic [5:0]         cyc_reg;
    logic [10:0]        dd_reg;
    logic [4:0]         hour_reg;
    logic [5:0]         min_reg;
    logic [5:0]         sec_reg;
    logic               bad_reg;
    logic               neg_reg;
    logic               res_valid_reg;
    esc_pkg::esc_out_t  res_data_reg;
    esc_pkg::esc_out_t  res_data_next;

    logic        accept;
    logic        bad_in;
    logic [32:0] sum;
    logic [32:0] sum_wrapped;
    logic        load;
    logic [7:0]  date_year;
    logic [3:0]  date_month;
    logic [4:0]  date_mday;
    logic [8:0]  date_yday;

    assign accept      = src_valid && src_ready;
    assign bad_in      = src_data.epoch_seconds[31];
    assign sum         = {src_data.epoch_seconds[31], src_data.epoch_seconds}
                       + (src_data.local_mode ? {{16{offset_reg[16]}}, offset_reg} : 33'd0);
    assign sum_wrapped = sum + esc_pkg::SEC_PER_DAY;
    assign load        = (state_reg == esc_pkg::ST_DONE) && (!res_valid_reg || res_ready);

    esc_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    esc_date u_date (
        .cycle_count (cyc_reg),
        .cycle_day   (dd_reg),
        .year        (date_year),
        .month       (date_month),
        .mday        (date_mday),
        .yday        (date_yday)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            esc_pkg::ST_IDLE:
            begin
                if (src_valid)
                begin
                    if (bad_in)
                        state_next = esc_pkg::ST_DONE;
                    else if (sum[32])
                        state_next = esc_pkg::ST_HOUR;
                    else
                        state_next = esc_pkg::ST_DAYS;
                end
            end
            esc_pkg::ST_DAYS: if (div_rsp.done) state_next = esc_pkg::ST_WDAY;
            esc_pkg::ST_WDAY: if (div_rsp.done) state_next = esc_pkg::ST_YEAR;
            esc_pkg::ST_YEAR: if (div_rsp.done) state_next = esc_pkg::ST_HOUR;
            esc_pkg::ST_HOUR: if (div_rsp.done) state_next = esc_pkg::ST_MIN;
            esc_pkg::ST_MIN:  if (div_rsp.done) state_next = esc_pkg::ST_DONE;
            esc_pkg::ST_DONE: if (load) state_next = esc_pkg::ST_IDLE;
            default:          state_next = esc_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        src_ready = 1'b0;
        div_req   = '0;
        case (state_reg)
            esc_pkg::ST_IDLE:
            begin
                src_ready = 1'b1;
                if (src_valid && !bad_in)
                begin
                    div_req.start = 1'b1;
                    if (sum[32])
                    begin
                        div_req.dividend = {15'd0, sum_wrapped[16:0]};
                        div_req.divisor  = esc_pkg::HOUR_DIVISOR;
                        div_req.steps    = esc_pkg::HOUR_STEPS;
                    end
                    else
                    begin
                        div_req.dividend = sum[31:0];
                        div_req.divisor  = esc_pkg::DAY_DIVISOR;
                        div_req.steps    = esc_pkg::DAY_STEPS;
                    end
                end
            end
            esc_pkg::ST_DAYS:
            begin
                div_req.start    = div_rsp.done;
                div_req.dividend = {16'd0, div_rsp.quotient} + 32'(esc_pkg::EPOCH_WEEKDAY);
                div_req.divisor  = esc_pkg::WEEK_DIVISOR;
                div_req.steps    = esc_pkg::WEEK_STEPS;
            end
            esc_pkg::ST_WDAY:
            begin
                div_req.start    = div_rsp.done;
                div_req.dividend = {16'd0, days_reg};
                div_req.divisor  = esc_pkg::QUAD_DIVISOR;
                div_req.steps    = esc_pkg::QUAD_STEPS;
            end
            esc_pkg::ST_YEAR:
            begin
                div_req.start    = div_rsp.done;
                div_req.dividend = {15'd0, secs_reg};
                div_req.divisor  = esc_pkg::HOUR_DIVISOR;
                div_req.steps    = esc_pkg::HOUR_STEPS;
            end
            esc_pkg::ST_HOUR:
            begin
                div_req.start    = div_rsp.done;
                div_req.dividend = div_rsp.remainder;
                div_req.divisor  = esc_pkg::MIN_DIVISOR;
                div_req.steps    = esc_pkg::MIN_STEPS;
            end
            default:
            begin
                src_ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= esc_pkg::ST_IDLE;
            offset_reg    <= esc_pkg::OFFSET_RESET;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                offset_reg <= cfg_data;
            if (load)
                res_valid_reg <= 1'b1;
            else if (res_ready)
                res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            bad_reg <= bad_in;
            neg_reg <= !bad_in && sum[32];
        end
        if (div_rsp.done)
        begin
            case (state_reg)
                esc_pkg::ST_DAYS:
                begin
                    days_reg <= div_rsp.quotient;
                    secs_reg <= div_rsp.remainder[16:0];
                end
                esc_pkg::ST_WDAY:
                begin
                    wday_reg <= div_rsp.remainder[2:0];
                end
                esc_pkg::ST_YEAR:
                begin
                    cyc_reg <= div_rsp.quotient[5:0];
                    dd_reg  <= div_rsp.remainder[10:0];
                end
                esc_pkg::ST_HOUR:
                begin
                    hour_reg <= div_rsp.quotient[4:0];
                end
                esc_pkg::ST_MIN:
                begin
                    min_reg <= div_rsp.quotient[5:0];
                    sec_reg <= div_rsp.remainder[5:0];
                end
                default:
                begin
                    days_reg <= days_reg;
                end
            endcase
        end
        if (load)
            res_data_reg <= res_data_next;
    end

    always_comb
    begin
        res_data_next = '0;
        if (bad_reg)
        begin
            res_data_next.bad_time = 1'b1;
        end
        else
        begin
            res_data_next.hour_of_day      = hour_reg;
            res_data_next.minute_of_hour   = min_reg;
            res_data_next.second_of_minute = sec_reg;
            if (neg_reg)
            begin
                res_data_next.year_since_1900 = esc_pkg::PRE_EPOCH_YEAR;
                res_data_next.month_index     = esc_pkg::PRE_EPOCH_MONTH;
                res_data_next.day_of_month    = esc_pkg::PRE_EPOCH_MDAY;
                res_data_next.day_of_year     = esc_pkg::PRE_EPOCH_YDAY;
                res_data_next.weekday         = esc_pkg::PRE_EPOCH_WDAY;
            end
            else
            begin
                res_data_next.year_since_1900 = date_year;
                res_data_next.month_index     = date_month;
                res_data_next.day_of_month    = date_mday;
                res_data_next.day_of_year     = date_yday;
                res_data_next.weekday         = wday_reg;
            end
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

endmodule

/* bench/tb_top.sv */
// ============================================================================
// tb_top: self-checking bench for epoch_seconds_to_calendar
// Feeds signed epoch timestamps in UTC and local mode through the block under
// several zone offsets, predicts each broken-down calendar result and checks
// every transaction field by field, with random idling on both sides.
// ============================================================================
module tb_top;

    localparam longint DAY_SECONDS   = 86400;
    localparam longint QUAD_DAYS     = 1461;
    localparam int     STALL_LIMIT   = 5000;
    localparam int     PHASES        = 8;
    localparam int     RANDOM_PER_PH = 185;
    localparam int     HOLD_CYCLES   = 300;
    localparam int     HOLD_AT_A     = 2000;
    localparam int     HOLD_AT_B     = 40000;

    logic                clk       = 1'b0;
    logic                rst_n     = 1'b0;
    logic                src_valid = 1'b0;
    logic                src_ready;
    esc_pkg::esc_in_t    src_data  = '0;
    logic                res_valid;
    logic                res_ready = 1'b0;
    esc_pkg::esc_out_t   res_data;
    logic                cfg_we    = 1'b0;
    logic signed [16:0]  cfg_data  = '0;

    esc_pkg::esc_in_t    stamp_queue [$];
    esc_pkg::esc_out_t   calendar_queue [$];
    logic signed [16:0]  zone_offset = 17'sd28800;
    logic signed [16:0]  zone_settings [PHASES];
    int                  days_in_month [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    bit                  calm;
    int                  mismatches;
    int                  results_seen;
    int                  rejected_seen;
    int                  pre_epoch_seen;
    int                  src_gap;
    int                  sink_gap;
    int                  hold_left;
    int                  hold_cycle;
    int                  stall_cycles;

    epoch_seconds_to_calendar dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .src_valid (src_valid),
        .src_ready (src_ready),
        .src_data  (src_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic esc_pkg::esc_out_t calendar_of(input esc_pkg::esc_in_t stamp,
                                                      input logic signed [16:0] offset);
        esc_pkg::esc_out_t cal;
        longint   secs;
        longint   days;
        longint   tod;
        longint   yday;
        longint   left;
        int       year;
        int       mon;
        int       mlen;
        bit       leap;
        cal = '0;
        if (stamp.epoch_seconds[31])
        begin
            cal.bad_time = 1'b1;
            return cal;
        end
        secs = longint'({32'd0, stamp.epoch_seconds});
        if (stamp.local_mode)
            secs += longint'(offset);
        if (secs < 0)
        begin
            cal.year_since_1900 = 8'd69;
            cal.month_index     = 4'd11;
            cal.day_of_month    = 5'd31;
            cal.day_of_year     = 9'd364;
            cal.weekday         = 3'd3;
            tod = secs + DAY_SECONDS;
        end
        else
        begin
            days = secs / DAY_SECONDS;
            tod  = secs % DAY_SECONDS;
            year = 70 + 4 * int'(days / QUAD_DAYS);
            yday = days % QUAD_DAYS;
            leap = 1'b0;
            if (yday >= 365)
            begin
                year++;
                yday -= 365;
                if (yday >= 365)
                begin
                    year++;
                    yday -= 365;
                    if (yday >= 366)
                    begin
                        year++;
                        yday -= 366;
                    end
                    else
                        leap = 1'b1;
                end
            end
            left = yday;
            mon  = 0;
            mlen = days_in_month[0];
            while (left >= mlen)
            begin
                left -= mlen;
                mon++;
                mlen = days_in_month[mon] + ((mon == 1 && leap) ? 1 : 0);
            end
            cal.year_since_1900 = 8'(year);
            cal.month_index     = 4'(mon);
            cal.day_of_month    = 5'(left + 1);
            cal.day_of_year     = 9'(yday);
            cal.weekday         = 3'((days + 4) % 7);
        end
        cal.hour_of_day      = 5'(tod / 3600);
        cal.minute_of_hour   = 6'((tod % 3600) / 60);
        cal.second_of_minute = 6'(tod % 60);
        return cal;
    endfunction

    task automatic flag_mismatch(input string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    task automatic compare_field(input string name, input logic [31:0] got,
                                 input logic [31:0] want);
        if (got !== want)
            flag_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
    endtask

    task automatic check_calendar(input esc_pkg::esc_out_t got,
                                  input esc_pkg::esc_out_t want);
        compare_field("bad_time", 32'(got.bad_time), 32'(want.bad_time));
        compare_field("year_since_1900", 32'(got.year_since_1900),
                      32'(want.year_since_1900));
        compare_field("month_index", 32'(got.month_index), 32'(want.month_index));
        compare_field("day_of_month", 32'(got.day_of_month), 32'(want.day_of_month));
        compare_field("day_of_year", 32'(got.day_of_year), 32'(want.day_of_year));
        compare_field("weekday", 32'(got.weekday), 32'(want.weekday));
        compare_field("hour_of_day", 32'(got.hour_of_day), 32'(want.hour_of_day));
        compare_field("minute_of_hour", 32'(got.minute_of_hour),
                      32'(want.minute_of_hour));
        compare_field("second_of_minute", 32'(got.second_of_minute),
                      32'(want.second_of_minute));
    endtask

    task automatic queue_stamp(input logic [31:0] raw, input logic mode);
        esc_pkg::esc_in_t stamp;
        stamp.epoch_seconds = raw;
        stamp.local_mode    = mode;
        stamp_queue.push_back(stamp);
    endtask

    task automatic queue_random_stamp();
        longint      day;
        longint      tod;
        logic [31:0] raw;
        case ($urandom_range(0, 9))
            0, 1: raw = $urandom();
            2: raw = $urandom_range(0, 200000);
            3: raw = 32'h7FFF_FFFF - $urandom_range(0, 200000);
            default:
            begin
                day = $urandom_range(0, 24854);
                case ($urandom_range(0, 3))
                    0: tod = 0;
                    1: tod = DAY_SECONDS - 1;
                    2: tod = $urandom_range(0, 3);
                    default: tod = $urandom_range(0, 86399);
                endcase
                raw = 32'(day * DAY_SECONDS + tod);
            end
        endcase
        queue_stamp(raw, 1'($urandom_range(0, 1)));
    endtask

    // Driver: offer queued timestamps, predict at acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_valid <= 1'b0;
            src_data  <= '0;
            src_gap    = 0;
        end
        else
        begin
            if (src_valid && src_ready)
                calendar_queue.push_back(calendar_of(src_data, zone_offset));
            if (!src_valid || src_ready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    src_valid <= 1'b0;
                end
                else if (!calm && stamp_queue.size() > 0 && $urandom_range(0, 9) == 0)
                begin
                    src_gap = $urandom_range(1, 10) - 1;
                    src_valid <= 1'b0;
                end
                else if (stamp_queue.size() > 0)
                begin
                    src_data  <= stamp_queue.pop_front();
                    src_valid <= 1'b1;
                end
                else
                    src_valid <= 1'b0;
            end
        end
    end

    // Long receiver hold: count cycles, hold off twice
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_cycle <= 0;
            hold_left  <= 0;
        end
        else
        begin
            hold_cycle <= hold_cycle + 1;
            if (hold_left > 0)
                hold_left <= hold_left - 1;
            else if (hold_cycle == HOLD_AT_A || hold_cycle == HOLD_AT_B)
                hold_left <= HOLD_CYCLES;
        end
    end

    // Monitor: check each result transaction, drive res_ready
    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        esc_pkg::esc_out_t want;
        if (!rst_n)
        begin
            res_ready <= 1'b0;
            sink_gap   = 0;
        end
        else
        begin
            if (res_valid && res_ready)
            begin
                if (calendar_queue.size() == 0)
                    flag_mismatch("result arrived with nothing expected");
                else
                begin
                    want = calendar_queue.pop_front();
                    check_calendar(res_data, want);
                    results_seen++;
                    if (want.bad_time)
                        rejected_seen++;
                    else if (want.year_since_1900 == 8'd69)
                        pre_epoch_seen++;
                end
            end
            if (hold_left > 0)
            begin
                res_ready <= 1'b0;
            end
            else if (sink_gap > 0)
            begin
                sink_gap--;
                res_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 9) == 0)
            begin
                sink_gap = $urandom_range(1, 10) - 1;
                res_ready <= 1'b0;
            end
            else
                res_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((src_valid && src_ready) || (res_valid && res_ready))
                stall_cycles = 0;
            else
                stall_cycles++;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("timeout: no transaction for %0d cycles", STALL_LIMIT);
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin
        logic signed [16:0] setting;
        zone_settings = '{17'sd28800, 17'sh1_0000, 17'sd65535, -17'sd50400,
                          17'sd50400, 17'sd0, -17'sd1, 17'sd0};
        zone_settings[PHASES - 1] = 17'($signed($urandom_range(0, 100800)) - 50400);
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        for (int ph = 0; ph < PHASES; ph++)
        begin
            setting = zone_settings[ph];
            if (ph > 0)
            begin
                @(posedge clk);
                cfg_we      <= 1'b1;
                cfg_data    <= setting;
                zone_offset  = setting;
                @(posedge clk);
                cfg_we <= 1'b0;
                @(negedge clk);
            end
            if (ph == PHASES - 1)
                calm = 1'b1;
            if (ph == 0)
            begin
                queue_stamp(32'd0, 1'b0);
                queue_stamp(32'd0, 1'b1);
                queue_stamp(32'h7FFF_FFFF, 1'b0);
                queue_stamp(32'h7FFF_FFFF, 1'b1);
                queue_stamp(32'h8000_0000, 1'b0);
                queue_stamp(32'h8000_0000, 1'b1);
                queue_stamp(32'hFFFF_FFFF, 1'b0);
                queue_stamp(32'hFFFF_FFFF, 1'b1);
                queue_stamp(32'd86399, 1'b0);
                queue_stamp(32'd86400, 1'b1);
                queue_stamp(32'd68169600, 1'b0);
                queue_stamp(32'd68256000, 1'b0);
                queue_stamp(32'd94694399, 1'b0);
                queue_stamp(32'd94694400, 1'b0);
                queue_stamp(32'd126230399, 1'b0);
                queue_stamp(32'd126230400, 1'b0);
                queue_stamp(32'd951782400, 1'b1);
                queue_stamp(32'd978307199, 1'b0);
                queue_stamp(32'd978307200, 1'b1);
            end
            else
            begin
                queue_stamp(32'd0, 1'b1);
                queue_stamp(32'h7FFF_FFFF, 1'b1);
                queue_stamp(32'hFFFF_FFFF, 1'b1);
                if (setting < 0)
                begin
                    queue_stamp(32'(-longint'(setting) - 1), 1'b1);
                    queue_stamp(32'(-longint'(setting)), 1'b1);
                end
            end
            for (int i = 0; i < RANDOM_PER_PH; i++)
                queue_random_stamp();
            while (stamp_queue.size() != 0 || src_valid || calendar_queue.size() != 0)
                @(negedge clk);
        end
        repeat (60) @(posedge clk);
        if (calendar_queue.size() != 0)
            flag_mismatch($sformatf("%0d expected results never arrived",
                                    calendar_queue.size()));
        $display("Checked %0d calendar results under %0d zone offsets,", results_seen,
                 PHASES);
        $display("including %0d negative inputs and %0d local times before 1970.",
                 rejected_seen, pre_epoch_seen);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

/* filelist.f */
sv/esc_pkg.sv
sv/esc_divider.sv
sv/esc_date.sv
sv/epoch_seconds_to_calendar.sv
bench/tb_top.sv
